/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the decoder modules; only u8d_step uses them.
// Each macro expects signals named clk and rst_n in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared widths, types and the lead byte decoder for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 31;
    localparam int CNT_W  = 3;
    localparam int CONT_W = 6;

    localparam logic [CNT_W-1:0] MAX_CONT = 3'd5;

    // One result item
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            bad_lead;
    } result_t;

    // Outcome of one decode step
    typedef struct packed {
        logic    emit;
        result_t res;
    } step_t;

    // Classification of a lead byte
    typedef struct packed {
        logic             emit;
        logic             bad;
        logic [CNT_W-1:0] left;
        logic [CP_W-1:0]  seed;
    } lead_t;

    function automatic lead_t decode_lead(input logic [BYTE_W-1:0] b);
        lead_t l;
        l = '0;
        unique casez (b)
            8'b0???????:
            begin
                l.emit = 1'b1;
                l.seed = {{(CP_W-BYTE_W){1'b0}}, b};
            end
            8'b110?????:
            begin
                l.left = 3'd1;
                l.seed = {{(CP_W-5){1'b0}}, b[4:0]};
            end
            8'b1110????:
            begin
                l.left = 3'd2;
                l.seed = {{(CP_W-4){1'b0}}, b[3:0]};
            end
            8'b11110???:
            begin
                l.left = 3'd3;
                l.seed = {{(CP_W-3){1'b0}}, b[2:0]};
            end
            8'b111110??:
            begin
                l.left = 3'd4;
                l.seed = {{(CP_W-2){1'b0}}, b[1:0]};
            end
            8'b1111110?:
            begin
                l.left = MAX_CONT;
                l.seed = {{(CP_W-1){1'b0}}, b[0]};
            end
            default:
            begin
                // continuation prefix, 0xFE or 0xFF in lead position
                l.emit = 1'b1;
                l.bad  = 1'b1;
            end
        endcase
        return l;
    endfunction

endpackage

/* rtl/utf8_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Byte-serial UTF-8 decoder, 1 to 6 byte forms, code points up to 31 bits.
//
//   channel   signals                          direction
//   input     in_valid, in_ready, byte_in      byte request in
//   output    out_valid, out_ready,            code point out
//             code_point, bad_lead
//
// One byte per cycle sustained while the output is not stalled; the byte that
// completes a result passes through the input register, then the result
// register, before its result is valid.
// Reset clears the decode state to expect a lead byte and empties both stages.
// A stalled output holds its result; input keeps flowing while the held byte
// yields no result or the result register frees this cycle.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [u8d_pkg::BYTE_W-1:0] byte_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [u8d_pkg::CP_W-1:0]   code_point,
    output logic                       bad_lead
);

    logic                       full;
    logic [u8d_pkg::BYTE_W-1:0] byte_q;
    logic                       consume;
    logic                       slot_free;
    u8d_pkg::step_t             step;

    // Consume the held byte when its result, if any, has a slot
    assign consume = full && (!step.emit || slot_free);

    u8d_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .byte_in  (byte_in),
        .consume  (consume),
        .full     (full),
        .byte_q   (byte_q)
    );

    u8d_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_q  (byte_q),
        .advance (consume),
        .step    (step)
    );

    u8d_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (consume && step.emit),
        .res        (step.res),
        .slot_free  (slot_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .bad_lead   (bad_lead)
    );

endmodule

/* rtl/u8d_in_stage.sv */
// ----------------------------------------------------------------------------
// u8d_in_stage
// Input register: holds one byte request until the decode step consumes it.
// ----------------------------------------------------------------------------
module u8d_in_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [u8d_pkg::BYTE_W-1:0] byte_in,
    input  logic                       consume,
    output logic                       full,
    output logic [u8d_pkg::BYTE_W-1:0] byte_q
);

    logic                       full_reg;
    logic                       full_next;
    logic [u8d_pkg::BYTE_W-1:0] byte_reg;

    // Take a new request when empty or when the held byte leaves this cycle
    assign in_ready  = !full_reg || consume;
    assign full_next = (in_valid && in_ready) || (full_reg && !consume);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= byte_in;
        end
    end

    assign full   = full_reg;
    assign byte_q = byte_reg;

endmodule

/* rtl/u8d_step.sv */
// ----------------------------------------------------------------------------
// u8d_step
// Decode state (accumulator and remaining continuation count) and the
// combinational step that one byte applies to it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module u8d_step (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [u8d_pkg::BYTE_W-1:0] byte_q,
    input  logic                       advance,
    output u8d_pkg::step_t             step
);

    logic [u8d_pkg::CP_W-1:0]  acc_reg;
    logic [u8d_pkg::CP_W-1:0]  acc_next;
    logic [u8d_pkg::CNT_W-1:0] left_reg;
    logic [u8d_pkg::CNT_W-1:0] left_next;
    logic [u8d_pkg::CP_W-1:0]  shifted;
    u8d_pkg::lead_t            lead;

    assign lead    = u8d_pkg::decode_lead(byte_q);
    assign shifted = {acc_reg[u8d_pkg::CP_W-u8d_pkg::CONT_W-1:0],
                      byte_q[u8d_pkg::CONT_W-1:0]};

    // Compute next state and the result for the held byte
    always_comb
    begin
        step = '0;
        if (left_reg != '0)
        begin
            acc_next  = shifted;
            left_next = left_reg - 3'd1;
            if (left_reg == 3'd1)
            begin
                step.emit           = 1'b1;
                step.res.code_point = shifted;
            end
        end
        else
        begin
            acc_next            = lead.seed;
            left_next           = lead.left;
            step.emit           = lead.emit;
            step.res.code_point = lead.seed;
            step.res.bad_lead   = lead.bad;
        end
    end

    // Advance state when the byte is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            left_reg <= '0;
        end
        else if (advance)
        begin
            acc_reg  <= acc_next;
            left_reg <= left_next;
        end
    end

    `ASSERT_ALWAYS(a_left_range, left_reg <= u8d_pkg::MAX_CONT)
    `ASSERT_ALWAYS(a_bad_is_zero, !step.res.bad_lead || (step.res.code_point == '0))
    `ASSERT_NEXT(a_bad_clears, advance && step.res.bad_lead, (left_reg == '0) && (acc_reg == '0))
    `ASSERT_NEXT(a_cont_counts, advance && (left_reg != '0), left_reg == $past(left_reg) - 3'd1)

endmodule

/* rtl/u8d_out_stage.sv */
// ----------------------------------------------------------------------------
// u8d_out_stage
// Result register: holds one decoded code point until the consumer takes it.
// ----------------------------------------------------------------------------
module u8d_out_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  u8d_pkg::result_t             res,
    output logic                         slot_free,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [u8d_pkg::CP_W-1:0]     code_point,
    output logic                         bad_lead
);

    logic             valid_reg;
    logic             valid_next;
    u8d_pkg::result_t res_reg;

    // Slot opens when empty or when the held result is taken now
    assign slot_free  = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid  = valid_reg;
    assign code_point = res_reg.code_point;
    assign bad_lead   = res_reg.bad_lead;

endmodule
